[design/bpf_pkg.sv]
`default_nettype none

package bpf_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned STORE_WORDS = 256;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
  localparam int unsigned CNT_W       = $clog2(STORE_WORDS + 1);
  localparam int unsigned FILL_W      = $clog2(WORD_BITS + 1);
  localparam int unsigned OFF_W       = $clog2(WORD_BITS);
  localparam int unsigned LEN_W       = 14;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned BCNT_W      = 4;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [BCNT_W-1:0] BCNT_MAX = BCNT_W'(BYTE_BITS);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_FLUSH,
    ST_FETCH,
    ST_LOAD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic push;
    logic pad;
    logic bit_val;
  } pk_cmd_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic pop;
    logic load;
  } up_cmd_t;

endpackage

`default_nettype wire

[design/bpf_word_ram.sv]
`default_nettype none

module bpf_word_ram import bpf_pkg::*; (
  input  logic                 clk_i,
  input  wr_req_t              wr_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_W-1:0]    raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [STORE_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/bpf_packer.sv]
`default_nettype none

module bpf_packer import bpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pk_cmd_t           cmd_i,
  output wr_req_t           wr_o,
  output logic [FILL_W-1:0] fill_o,
  output logic [CNT_W-1:0]  words_o,
  output logic              store_full_o,
  output logic              pad_done_o
);

  logic [WORD_BITS-1:0] pack_q, pack_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]     words_q, words_d;
  logic                 full_w, empty_w, store_now;

  assign full_w  = (fill_q == FILL_W'(WORD_BITS));
  assign empty_w = (fill_q == '0);

  // word enters at the LSB end, so a full word is MSB-first; padding shifts zeros in
  always_comb begin
    pack_d    = pack_q;
    fill_d    = fill_q;
    words_d   = words_q;
    store_now = 1'b0;
    if (cmd_i.push) begin
      if (full_w) begin
        store_now = 1'b1;
        pack_d    = {{(WORD_BITS-1){1'b0}}, cmd_i.bit_val};
        fill_d    = FILL_W'(1);
      end else begin
        pack_d = {pack_q[WORD_BITS-2:0], cmd_i.bit_val};
        fill_d = fill_q + 1'b1;
      end
    end else if (cmd_i.pad) begin
      if (full_w || empty_w) begin
        store_now = 1'b1;
        pack_d    = '0;
        fill_d    = '0;
      end else begin
        pack_d = {pack_q[WORD_BITS-2:0], 1'b0};
        fill_d = fill_q + 1'b1;
      end
    end
    if (store_now) begin
      words_d = words_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q  <= '0;
      fill_q  <= '0;
      words_q <= '0;
    end else begin
      pack_q  <= pack_d;
      fill_q  <= fill_d;
      words_q <= words_d;
    end
  end

  assign wr_o.en      = store_now;
  assign wr_o.addr    = words_q[ADDR_W-1:0];
  assign wr_o.data    = pack_q;
  assign fill_o       = fill_q;
  assign words_o      = words_q;
  assign store_full_o = (words_q == CNT_W'(STORE_WORDS));
  assign pad_done_o   = full_w || empty_w;

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !store_full_o) else $error("store write while full");

  a_words_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    words_q <= CNT_W'(STORE_WORDS)) else $error("word count out of range");

endmodule

`default_nettype wire

[design/bpf_unpacker.sv]
`default_nettype none

module bpf_unpacker import bpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  up_cmd_t              cmd_i,
  input  logic [CNT_W-1:0]     words_i,
  input  logic [WORD_BITS-1:0] rdata_i,
  output logic [ADDR_W-1:0]    raddr_o,
  output logic                 avail_o,
  output logic                 cur_bit_o,
  output logic                 need_fetch_o
);

  logic [WORD_BITS-1:0] rd_sh_q, rd_sh_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [OFF_W-1:0]     off_q, off_d;
  logic                 loaded_q, loaded_d;

  always_comb begin
    rd_sh_d  = rd_sh_q;
    idx_d    = idx_q;
    off_d    = off_q;
    loaded_d = loaded_q;
    if (cmd_i.load) begin
      rd_sh_d  = rdata_i;
      loaded_d = 1'b1;
    end else if (cmd_i.pop) begin
      rd_sh_d = {rd_sh_q[WORD_BITS-2:0], 1'b0};
      if (off_q == OFF_W'(WORD_BITS - 1)) begin
        off_d    = '0;
        idx_d    = idx_q + 1'b1;
        loaded_d = 1'b0;
      end else begin
        off_d = off_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      off_q    <= '0;
      loaded_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      off_q    <= off_d;
      loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sh_q <= rd_sh_d;
  end

  assign raddr_o      = idx_q[ADDR_W-1:0];
  assign avail_o      = (idx_q < words_i);
  assign cur_bit_o    = rd_sh_q[WORD_BITS-1];
  assign need_fetch_o = avail_o && !loaded_q;

  a_read_behind_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= words_i) else $error("read index passed stored words");

  a_loaded_is_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |-> avail_o) else $error("loaded word not in store");

endmodule

`default_nettype wire

[design/bit_pack_unpack_fifo.sv]
// Bit FIFO: appended bits are packed MSB-first into 32-bit words kept in a
// 256-word store; pops return stored bits MSB-first, one per request.
// Input channel (in_valid_i/in_ready_o): operation_i, data_byte_i, bit_count_i.
// Output channel (out_valid_o/out_ready_i): one result per request with
// bit_res_o, bit_valid_o, length_o and overflow_o.
// Appended bits move through the pack shift register one per cycle; a flush
// pads the partial word by shifting in zeros one per cycle before storing it.
// Pops shift bits out of a read shift register loaded from the store.
// A pop or dropped request passes from IDLE through FETCH, then LOAD when a
// new stored word must be fetched, then DONE, which registers the result; an
// append first shifts its bits in APPEND and a flush pads in FLUSH. The next
// request is taken in IDLE once the result is registered, so a request is
// finished before another one is accepted.
// The output register holds a result until taken; the next request is
// accepted meanwhile and its result waits in the last state until the output
// register frees up.
// Reset empties the store, pack word, read position and length at once; the
// store array itself is not cleared.
`default_nettype none

module bit_pack_unpack_fifo import bpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [BYTE_BITS-1:0] data_byte_i,
  input  logic [BCNT_W-1:0]    bit_count_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 bit_res_o,
  output logic                 bit_valid_o,
  output logic [LEN_W-1:0]     length_o,
  output logic                 overflow_o
);

  state_e state_q, state_d;

  logic [BYTE_BITS-1:0] byte_q, byte_d;
  logic [BCNT_W-1:0]    cnt_q, cnt_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 popped_q, popped_d;
  logic                 pbit_q, pbit_d;
  logic                 ovf_q, ovf_d;

  logic                 out_valid_q, out_valid_d;
  logic                 bit_res_q, bit_res_d;
  logic                 bit_valid_q, bit_valid_d;
  logic [LEN_W-1:0]     out_len_q, out_len_d;
  logic                 out_ovf_q, out_ovf_d;

  pk_cmd_t              pk_cmd;
  up_cmd_t              up_cmd;
  wr_req_t              wr_req;
  logic [FILL_W-1:0]    fill;
  logic [CNT_W-1:0]     words;
  logic                 store_full, pad_done;
  logic [ADDR_W-1:0]    raddr;
  logic [WORD_BITS-1:0] rdata;
  logic                 rd_en, avail, cur_bit, need_fetch;

  logic [BCNT_W-1:0]    n_clamp;
  logic [FILL_W:0]      fill_sum;
  logic                 needs_store;
  logic [LEN_W:0]       len_sum;

  bpf_packer u_packer (
    .clk_i,
    .rst_ni,
    .cmd_i        (pk_cmd),
    .wr_o         (wr_req),
    .fill_o       (fill),
    .words_o      (words),
    .store_full_o (store_full),
    .pad_done_o   (pad_done)
  );

  bpf_word_ram u_ram (
    .clk_i,
    .wr_i    (wr_req),
    .rd_en_i (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bpf_unpacker u_unpacker (
    .clk_i,
    .rst_ni,
    .cmd_i        (up_cmd),
    .words_i      (words),
    .rdata_i      (rdata),
    .raddr_o      (raddr),
    .avail_o      (avail),
    .cur_bit_o    (cur_bit),
    .need_fetch_o (need_fetch)
  );

  assign n_clamp     = (bit_count_i > BCNT_MAX) ? BCNT_MAX : bit_count_i;
  assign fill_sum    = (FILL_W+1)'(fill) + (FILL_W+1)'(n_clamp);
  assign needs_store = (fill_sum > (FILL_W+1)'(WORD_BITS));
  assign len_sum     = (LEN_W+1)'(len_q) + (LEN_W+1)'(n_clamp);

  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    popped_d    = popped_q;
    pbit_d      = pbit_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    bit_res_d   = bit_res_q;
    bit_valid_d = bit_valid_q;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;
    pk_cmd      = '0;
    up_cmd      = '0;
    rd_en       = 1'b0;
    in_ready_o  = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          byte_d   = data_byte_i;
          cnt_d    = n_clamp;
          popped_d = 1'b0;
          pbit_d   = 1'b0;
          ovf_d    = 1'b0;
          state_d  = ST_FETCH;
          unique case (operation_i)
            OP_APPEND: begin
              if (needs_store && store_full) begin
                ovf_d = 1'b1;
              end else begin
                len_d = (len_sum > (LEN_W+1)'(LEN_MAX)) ? LEN_MAX : len_sum[LEN_W-1:0];
                if (n_clamp != '0) begin
                  state_d = ST_APPEND;
                end
              end
            end
            OP_FLUSH: begin
              if (store_full) begin
                ovf_d = 1'b1;
              end else begin
                state_d = ST_FLUSH;
              end
            end
            OP_POP: begin
              if (avail) begin
                pbit_d     = cur_bit;
                popped_d   = 1'b1;
                up_cmd.pop = 1'b1;
                if (len_q != '0) begin
                  len_d = len_q - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_APPEND: begin
        pk_cmd.push    = 1'b1;
        pk_cmd.bit_val = byte_q[BYTE_BITS-1];
        byte_d         = {byte_q[BYTE_BITS-2:0], 1'b0};
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == BCNT_W'(1)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FLUSH: begin
        pk_cmd.pad = 1'b1;
        if (pad_done) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (need_fetch) begin
          rd_en   = 1'b1;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LOAD: begin
        up_cmd.load = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          bit_res_d   = popped_q ? pbit_q : (avail && cur_bit);
          bit_valid_d = popped_q || avail;
          out_len_d   = len_q;
          out_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      popped_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      popped_q    <= popped_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    cnt_q       <= cnt_d;
    pbit_q      <= pbit_d;
    bit_res_q   <= bit_res_d;
    bit_valid_q <= bit_valid_d;
    out_len_q   <= out_len_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign bit_res_o   = bit_res_q;
  assign bit_valid_o = bit_valid_q;
  assign length_o    = out_len_q;
  assign overflow_o  = out_ovf_q;

  a_idle_word_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !need_fetch) else $error("idle without current word loaded");

  a_invalid_bit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !bit_valid_q |-> !bit_res_q) else $error("bit set without valid");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != ST_IDLE) else $error("request not started");

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
  import bpf_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_DIR     = 24;
  localparam int RAND_REQS = 900;

  typedef struct packed {
    logic             bit_res;
    logic             bit_valid;
    logic [LEN_W-1:0] length;
    logic             overflow;
  } result_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [BYTE_BITS-1:0] data;
    logic [BCNT_W-1:0]    cnt;
    logic                 typed;
    result_t              res;
  } dir_row_t;

  // typed rows: expectations read straight off the spec
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{OP_POP,    8'h00, 4'd1,  1'b1, '{1'b0, 1'b0, 14'd0,  1'b0}},
    '{OP_UNUSED, 8'hff, 4'd8,  1'b1, '{1'b0, 1'b0, 14'd0,  1'b0}},
    '{OP_APPEND, 8'hff, 4'd0,  1'b1, '{1'b0, 1'b0, 14'd0,  1'b0}},
    '{OP_APPEND, 8'ha5, 4'd8,  1'b1, '{1'b0, 1'b0, 14'd8,  1'b0}},
    '{OP_APPEND, 8'h3c, 4'd15, 1'b1, '{1'b0, 1'b0, 14'd16, 1'b0}},
    '{OP_FLUSH,  8'h00, 4'd0,  1'b1, '{1'b1, 1'b1, 14'd16, 1'b0}},
    '{OP_POP,    8'h00, 4'd0,  1'b1, '{1'b1, 1'b1, 14'd15, 1'b0}},
    '{OP_POP,    8'hff, 4'd15, 1'b1, '{1'b0, 1'b1, 14'd14, 1'b0}},
    '{OP_FLUSH,  8'hff, 4'd8,  1'b1, '{1'b1, 1'b1, 14'd14, 1'b0}},
    '{OP_APPEND, 8'h80, 4'd1,  1'b1, '{1'b1, 1'b1, 14'd15, 1'b0}},
    '{OP_APPEND, 8'hff, 4'd8,  1'b0, '0},
    '{OP_APPEND, 8'h00, 4'd8,  1'b0, '0},
    '{OP_APPEND, 8'hff, 4'd8,  1'b0, '0},
    '{OP_APPEND, 8'h7f, 4'd7,  1'b0, '0},
    '{OP_POP,    8'h00, 4'd0,  1'b0, '0},
    '{OP_APPEND, 8'h80, 4'd1,  1'b0, '0},
    '{OP_UNUSED, 8'h00, 4'd0,  1'b0, '0},
    '{OP_APPEND, 8'h55, 4'd9,  1'b0, '0},
    '{OP_FLUSH,  8'h00, 4'd0,  1'b0, '0},
    '{OP_POP,    8'hff, 4'd15, 1'b0, '0},
    '{OP_POP,    8'h00, 4'd0,  1'b0, '0},
    '{OP_POP,    8'hff, 4'd8,  1'b0, '0},
    '{OP_POP,    8'h00, 4'd1,  1'b0, '0},
    '{OP_POP,    8'hff, 4'd15, 1'b0, '0}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [1:0]           operation_i = '0;
  logic [BYTE_BITS-1:0] data_byte_i = '0;
  logic [BCNT_W-1:0]    bit_count_i = '0;
  logic                 out_ready_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 bit_res_o;
  logic                 bit_valid_o;
  logic [LEN_W-1:0]     length_o;
  logic                 overflow_o;

  bit_pack_unpack_fifo u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .bit_count_i (bit_count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bit_res_o   (bit_res_o),
    .bit_valid_o (bit_valid_o),
    .length_o    (length_o),
    .overflow_o  (overflow_o)
  );

  // predictor state
  logic [WORD_BITS-1:0] mem_words [STORE_WORDS];
  int unsigned          n_words  = 0;
  logic [WORD_BITS-1:0] pk_word  = '0;
  int unsigned          pk_fill  = 0;
  int unsigned          rd_word  = 0;
  int unsigned          rd_bit   = 0;
  int unsigned          len_bits = 0;

  result_t owed_results [$];
  int n_req = 0, n_res = 0, n_err = 0, n_drop = 0, n_dry = 0;
  int burst_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void store_pack_word();
    mem_words[n_words] = pk_word;
    n_words++;
    pk_word = '0;
    pk_fill = 0;
  endfunction

  function automatic result_t bitfifo_step(input logic [1:0] op,
                                           input logic [BYTE_BITS-1:0] d,
                                           input logic [BCNT_W-1:0] c);
    result_t     r;
    int unsigned n;
    r = '0;
    n = (c > BCNT_MAX) ? BYTE_BITS : int'(c);
    case (op)
      OP_APPEND: begin
        if (pk_fill + n > WORD_BITS && n_words >= STORE_WORDS) begin
          r.overflow = 1'b1;
        end else begin
          for (int unsigned k = 0; k < n; k++) begin
            if (pk_fill >= WORD_BITS) store_pack_word();
            if (d[BYTE_BITS-1-k]) pk_word[WORD_BITS-1-pk_fill] = 1'b1;
            pk_fill++;
          end
          len_bits = (len_bits + n > LEN_MAX) ? LEN_MAX : len_bits + n;
        end
      end
      OP_FLUSH: begin
        if (n_words >= STORE_WORDS) r.overflow = 1'b1;
        else store_pack_word();
      end
      default: ;
    endcase
    if (rd_word < n_words && rd_word < STORE_WORDS) begin
      r.bit_res   = mem_words[rd_word][WORD_BITS-1-rd_bit];
      r.bit_valid = 1'b1;
      if (op == OP_POP) begin
        rd_bit++;
        if (rd_bit >= WORD_BITS) begin
          rd_bit = 0;
          rd_word++;
        end
        if (len_bits > 0) len_bits--;
      end
    end
    r.length = LEN_W'(len_bits);
    return r;
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [BYTE_BITS-1:0] d,
                          input logic [BCNT_W-1:0] c, input logic typed,
                          input result_t typed_res);
    result_t r;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_byte_i <= d;
    bit_count_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    r = bitfifo_step(op, d, c);
    n_req++;
    if (op == OP_POP && !r.bit_valid) n_dry++;
    if (r.overflow) n_drop++;
    owed_results.insert(owed_results.size(), typed ? typed_res : r);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_res++;
      if (owed_results.size() == 0) begin
        $display("%0t: result with no request pending: bit=%0b valid=%0b len=%0d ovf=%0b",
                 $time, bit_res_o, bit_valid_o, length_o, overflow_o);
        n_err++;
      end else begin
        want = owed_results.pop_front();
        check_field("bit_res",   want.bit_res,   bit_res_o);
        check_field("bit_valid", want.bit_valid, bit_valid_o);
        check_field("length",    want.length,    length_o);
        check_field("overflow",  want.overflow,  overflow_o);
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int unsigned mode, mode_left;
    bit held;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && n_req >= 300) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [1:0]           op;
    logic [BYTE_BITS-1:0] d;
    logic [BCNT_W-1:0]    c;
    int unsigned          pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < N_DIR; k++) begin
      send_req(DIRECTED[k].op, DIRECTED[k].data, DIRECTED[k].cnt,
               DIRECTED[k].typed, DIRECTED[k].res);
      pace_sender();
    end
    // drain the read side first, then mixed traffic that fills the store
    for (int i = 0; i < RAND_REQS; i++) begin
      pick = $urandom_range(0, 99);
      if (i < 120) op = OP_POP;
      else if (i < 420) begin
        if (pick < 45) op = OP_APPEND;
        else if (pick < 65) op = OP_FLUSH;
        else if (pick < 95) op = OP_POP;
        else op = OP_UNUSED;
      end else begin
        if (pick < 30) op = OP_APPEND;
        else if (pick < 75) op = OP_FLUSH;
        else if (pick < 97) op = OP_POP;
        else op = OP_UNUSED;
      end
      d = BYTE_BITS'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 85) c = BCNT_W'($urandom_range(1, 8));
      else c = BCNT_W'($urandom_range(0, 15));
      send_req(op, d, c, 1'b0, '0);
      if (i == 600) begin
        in_valid_i <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk_i);
      end else begin
        pace_sender();
      end
    end
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    $display("run: %0d requests, %0d results checked, %0d of %0d store words written",
             n_req, n_res, n_words, STORE_WORDS);
    $display("run: %0d requests dropped on a full store, %0d pops with no stored bit",
             n_drop, n_dry);
    if (n_err == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout, %0d results still pending", owed_results.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
